FILE: src/tvi_pkg.sv
// Shared types, constants and helper functions of the trilinear volume interpolator.
`default_nettype none
package tvi_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VADDR_W   = 18;
    localparam int VOL_WORDS = 262144;
    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 8;
    localparam int SIZE_W    = 7;
    localparam int IDX_W     = 7;
    localparam int T1_W      = 15;
    localparam int PLANE_W   = 14;
    localparam int LIN_W     = 22;
    localparam int WGT_W     = FRAC_W + 1;
    localparam int W2_W      = 2 * WGT_W;
    localparam int W3_W      = 3 * FRAC_W + 1;
    localparam int OUT_W     = 40;
    localparam int CORNERS   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Contents of the first front stage.
    typedef struct packed {
        t_op                 kind;
        logic [VADDR_W-1:0]  waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic                in_cell;
        logic [IDX_W-1:0]    bx;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fy;
        logic [FRAC_W-1:0]   fz;
        logic [T1_W-1:0]     t1;
    } t_s1;

    // Contents of the second front stage, as handed to the memory stage.
    typedef struct packed {
        t_op                      kind;
        logic [VADDR_W-1:0]       waddr;
        logic [SAMPLE_W-1:0]      wdata;
        logic                     in_cell;
        logic [LIN_W-1:0]         base;
        logic [PLANE_W-1:0]       plane;
        logic [FRAC_W-1:0]        fz;
        logic [3:0][W2_W-1:0]     wxy;
    } t_s2;

    // Per-query flags leaving the memory stage.
    typedef struct packed {
        logic                in_cell;
        logic [CORNERS-1:0]  ok;
    } t_flags;

    // Base corner on one axis: floor(coordinate) minus one, as a 9-bit signed value.
    function automatic logic [FRAC_W:0] base_of(input logic [COORD_W-1:0] c);
        return {c[COORD_W-1], c[COORD_W-1:FRAC_W]} - 9'd1;
    endfunction

    // The base lies from 1 to size-2.
    function automatic logic axis_ok(input logic [FRAC_W:0] b, input logic [SIZE_W-1:0] sz);
        return !b[FRAC_W] && (b != 9'd0) && (({1'b0, b[7:0]} + 9'd2) <= {2'b0, sz});
    endfunction

endpackage
`default_nettype wire

FILE: src/tvi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tvi_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/tvi_front.sv
// Front pipeline: range check, base address and the x-y weight products.
`default_nettype none
module tvi_front import tvi_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_opcode,
    input  wire logic [VADDR_W-1:0]        i_voxel_address,
    input  wire logic [SAMPLE_W-1:0]       i_voxel_value,
    input  wire logic [COORD_W-1:0]        i_coord_x,
    input  wire logic [COORD_W-1:0]        i_coord_y,
    input  wire logic [COORD_W-1:0]        i_coord_z,
    input  wire logic [SIZE_W-1:0]         i_size_x,
    input  wire logic [SIZE_W-1:0]         i_size_y,
    input  wire logic [SIZE_W-1:0]         i_size_z,
    input  wire logic                      i_next_load,
    output logic                           o_valid,
    output t_s2                            o_item
);

    logic     r1_v, r2_v;
    t_s1      r1, n1;
    t_s2      r2, n2;
    logic     load1, load2;
    logic [FRAC_W:0] bx, by, bz;
    logic [WGT_W-1:0] wgx [2];
    logic [WGT_W-1:0] wgy [2];

    assign load2   = !r2_v || i_next_load;
    assign load1   = !r1_v || load2;
    assign o_ready = load1;
    assign o_valid = r2_v;
    assign o_item  = r2;

    always_comb begin
        bx = base_of(i_coord_x);
        by = base_of(i_coord_y);
        bz = base_of(i_coord_z);
        n1.kind    = t_op'(i_opcode);
        n1.waddr   = i_voxel_address;
        n1.wdata   = i_voxel_value;
        n1.in_cell = axis_ok(bx, i_size_x) && axis_ok(by, i_size_y) && axis_ok(bz, i_size_z);
        n1.bx      = bx[IDX_W-1:0];
        n1.fx      = i_coord_x[FRAC_W-1:0];
        n1.fy      = i_coord_y[FRAC_W-1:0];
        n1.fz      = i_coord_z[FRAC_W-1:0];
        n1.t1      = {8'b0, by[IDX_W-1:0]} + ({8'b0, bz[IDX_W-1:0]} * {8'b0, i_size_y});
    end

    always_comb begin
        wgx[0] = 9'd256 - {1'b0, r1.fx};
        wgx[1] = {1'b0, r1.fx};
        wgy[0] = 9'd256 - {1'b0, r1.fy};
        wgy[1] = {1'b0, r1.fy};
        n2.kind    = r1.kind;
        n2.waddr   = r1.waddr;
        n2.wdata   = r1.wdata;
        n2.in_cell = r1.in_cell;
        n2.fz      = r1.fz;
        n2.base    = {15'b0, r1.bx} + ({7'b0, r1.t1} * {15'b0, i_size_x});
        n2.plane   = {7'b0, i_size_x} * {7'b0, i_size_y};
        for (int c = 0; c < 4; c++) begin
            n2.wxy[c] = {9'b0, wgx[c % 2]} * {9'b0, wgy[c / 2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (load1) r1_v <= i_valid;
            if (load2) r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) r1 <= n1;
        if (load2) r2 <= n2;
    end

endmodule
`default_nettype wire

FILE: src/tvi_blend.sv
// Back pipeline: corner products, adder tree and the output register.
`default_nettype none
module tvi_blend import tvi_pkg::*; (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire t_flags                            i_flags,
    input  wire logic [CORNERS-1:0][SAMPLE_W-1:0]  i_sample,
    input  wire logic [CORNERS-1:0][W3_W-1:0]      i_weight,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [OUT_W-1:0]                       o_interp_value,
    output logic                                   o_in_range
);

    logic r4_v, r5_v, r6_v, r_out_v;
    logic r4_in, r5_in, r6_in;
    logic [OUT_W-1:0] r4_p [CORNERS];
    logic [OUT_W-1:0] r5_s [4];
    logic [OUT_W-1:0] r6_s [2];
    logic [OUT_W-1:0] r_val;
    logic r_rng;
    logic load4, load5, load6, load_out;

    assign load_out = !r_out_v || i_ready;
    assign load6    = !r6_v || load_out;
    assign load5    = !r5_v || load6;
    assign load4    = !r4_v || load5;
    assign o_ready  = load4;
    assign o_valid  = r_out_v;
    assign o_interp_value = r_val;
    assign o_in_range     = r_rng;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (load4)    r4_v    <= i_valid;
            if (load5)    r5_v    <= r4_v;
            if (load6)    r6_v    <= r5_v;
            if (load_out) r_out_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load4) begin
            r4_in <= i_flags.in_cell;
            for (int c = 0; c < CORNERS; c++) begin
                // Corners that fall past the end of memory count as zero.
                r4_p[c] <= i_flags.ok[c] ?
                           ({24'b0, i_sample[c]} * {15'b0, i_weight[c]}) : '0;
            end
        end
        if (load5) begin
            r5_in <= r4_in;
            for (int c = 0; c < 4; c++) begin
                r5_s[c] <= r4_p[2*c] + r4_p[2*c+1];
            end
        end
        if (load6) begin
            r6_in   <= r5_in;
            r6_s[0] <= r5_s[0] + r5_s[1];
            r6_s[1] <= r5_s[2] + r5_s[3];
        end
        if (load_out) begin
            r_rng <= r6_in;
            r_val <= r6_in ? (r6_s[0] + r6_s[1]) : '0;
        end
    end

endmodule
`default_nettype wire

FILE: src/trilinear_volume_interpolator.sv
// Top level of the trilinear volume interpolator: configuration, volume memories, pipeline.
// Throughput: one item per cycle, writes and queries alike, while the result side does not
// stall; the eight corner reads share a cycle because the volume is held in eight replicated
// memories, each read at one corner.
// Reset: synchronous, active low; it clears the pipeline valid bits and sets every size to 64.
// The volume memories are not cleared; a voxel must be written before it is read.
`default_nettype none
module trilinear_volume_interpolator import tvi_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_opcode,
    input  wire logic [VADDR_W-1:0]        i_voxel_address,
    input  wire logic [SAMPLE_W-1:0]       i_voxel_value,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    input  wire logic signed [COORD_W-1:0] i_coord_z,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [SIZE_W-1:0]         i_cfg_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [OUT_W-1:0]               o_interp_value,
    output logic                           o_in_range
);

    // Configuration registers. The user changes them only while the block is idle; unchecked.
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 7'd64;
            r_size_y <= 7'd64;
            r_size_z <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Front pipeline: two stages that find the base corner, check the cell lies
    // inside and build the linear base address and the x-y weight products.
    logic front_v;
    t_s2  front_item;
    logic load3;

    tvi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_size_x        (r_size_x),
        .i_size_y        (r_size_y),
        .i_size_z        (r_size_z),
        .i_next_load     (load3),
        .o_valid         (front_v),
        .o_item          (front_item)
    );

    // Memory stage. Every write goes to all eight copies, and each copy serves
    // one corner of the cell. Writes and reads happen at the same point of the
    // pipeline, so a query always sees every write that was accepted before it.
    logic                              blend_ready;
    logic                              r3_v;
    t_flags                            r3_flags;
    logic [CORNERS-1:0][W3_W-1:0]      r3_w;
    logic [CORNERS-1:0][SAMPLE_W-1:0]  rd_data;
    logic [CORNERS-1:0][LIN_W-1:0]     corner_addr;
    logic [WGT_W-1:0]                  wgz [2];
    logic                              mem_we;

    assign load3  = !r3_v || blend_ready;
    assign mem_we = front_v && (front_item.kind == OP_WRITE) && load3;

    always_comb begin
        wgz[0] = 9'd256 - {1'b0, front_item.fz};
        wgz[1] = {1'b0, front_item.fz};
        for (int c = 0; c < CORNERS; c++) begin
            corner_addr[c] = front_item.base + LIN_W'(c % 2)
                           + (((c / 2) % 2 == 1) ? {15'b0, r_size_x} : '0)
                           + ((c / 4 == 1) ? {8'b0, front_item.plane} : '0);
        end
    end

    for (genvar g = 0; g < CORNERS; g++) begin : g_bank
        tvi_ram #(
            .DATA_W (SAMPLE_W),
            .DEPTH  (VOL_WORDS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (mem_we),
            .i_waddr (front_item.waddr),
            .i_wdata (front_item.wdata),
            .i_re    (load3),
            .i_raddr (corner_addr[g][VADDR_W-1:0]),
            .o_rdata (rd_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (load3) begin
            // Write items end here; only queries go on to the blend.
            r3_v <= front_v && (front_item.kind == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load3) begin
            r3_flags.in_cell <= front_item.in_cell;
            for (int c = 0; c < CORNERS; c++) begin
                r3_flags.ok[c] <= (corner_addr[c][LIN_W-1:VADDR_W] == '0);
                r3_w[c] <= {7'b0, front_item.wxy[c % 4]} * {16'b0, wgz[c / 4]};
            end
        end
    end

    // Back pipeline: products, adder tree and the output register, which lets
    // the earlier stages keep moving while a finished result waits.
    tvi_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r3_v),
        .o_ready        (blend_ready),
        .i_flags        (r3_flags),
        .i_sample       (rd_data),
        .i_weight       (r3_w),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_interp_value (o_interp_value),
        .o_in_range     (o_in_range)
    );

    // A cell outside the volume always reports zero.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_interp_value == '0))
        else $error("outside item with a non-zero value");

    // The input side stalls only when a result is held at the output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a held result");

    // A write never reaches the memories while the memory stage is held.
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (load3 && front_item.kind == OP_WRITE))
        else $error("memory write during a hold");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench of the trilinear volume interpolator: predicted blends checked against every result.
`default_nettype none
module tb_top;
    import tvi_pkg::*;

    // Clock and reset.
    logic i_clk;
    logic i_rst_n;

    // Item channel into the block.
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_opcode;
    logic [VADDR_W-1:0]        i_voxel_address;
    logic [SAMPLE_W-1:0]       i_voxel_value;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic signed [COORD_W-1:0] i_coord_z;

    // Configuration write port.
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;

    // Result channel out of the block.
    logic             o_valid;
    logic             i_ready;
    logic [OUT_W-1:0] o_interp_value;
    logic             o_in_range;

    // One expected answer to a query.
    typedef struct {
        logic [OUT_W-1:0] blend;
        logic             in_cell;
    } t_answer;

    // Our own copy of the volume and of the sizes.  The volume is an associative
    // array so that only written voxels exist; every query that lands inside a cell aims at
    // a cell whose eight corners have been written.
    logic [SAMPLE_W-1:0] shadow_volume [int];
    int unsigned         ext_x, ext_y, ext_z;
    t_answer             pending_answers [$];

    int  error_count;
    int  idle_cycles;
    int  sent_items;
    bit  pass_ok;

    trilinear_volume_interpolator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_interp_value  (o_interp_value),
        .o_in_range      (o_in_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Split a Q8.8 coordinate into its floor and its fraction.
    function automatic void split_q88(input logic [COORD_W-1:0] raw, output int whole,
                                      output int unsigned frac);
        whole = $signed(raw[COORD_W-1:FRAC_W]);
        frac  = raw[FRAC_W-1:0];
    endfunction

    // Works out the exact trilinear blend that the block must return for a query.
    function automatic t_answer blend_at(input logic [COORD_W-1:0] cx,
                                         input logic [COORD_W-1:0] cy,
                                         input logic [COORD_W-1:0] cz);
        t_answer     ans;
        int          bx, by, bz;
        int unsigned fx, fy, fz;
        longint unsigned wx [2], wy [2], wz [2];
        longint unsigned total, addr, sample;
        split_q88(cx, bx, fx);
        split_q88(cy, by, fy);
        split_q88(cz, bz, fz);
        bx -= 1;
        by -= 1;
        bz -= 1;
        ans.blend   = '0;
        ans.in_cell = 1'b0;
        // Base 0 is excluded as well as anything past size-2.
        if (bx < 1 || bx > int'(ext_x) - 2 || by < 1 || by > int'(ext_y) - 2 ||
            bz < 1 || bz > int'(ext_z) - 2)
            return ans;
        wx[0] = 256 - fx; wx[1] = fx;
        wy[0] = 256 - fy; wy[1] = fy;
        wz[0] = 256 - fz; wz[1] = fz;
        total = 0;
        for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++) begin
                    addr = (bx + i) + ((by + j) + (bz + k) * ext_y) * ext_x;
                    sample = 0;
                    if (addr < VOL_WORDS && shadow_volume.exists(int'(addr)))
                        sample = shadow_volume[int'(addr)];
                    total += sample * wx[i] * wy[j] * wz[k];
                end
        ans.blend   = total[OUT_W-1:0];
        ans.in_cell = 1'b1;
        return ans;
    endfunction

    // Sends one item and waits until it is accepted.  The prediction is made at
    // acceptance so that it sees the volume exactly as the block does.  Valid is
    // dropped only when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input t_op kind, input logic [VADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] value, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= kind;
        i_voxel_address <= addr;
        i_voxel_value   <= value;
        i_coord_x       <= cx;
        i_coord_y       <= cy;
        i_coord_z       <= cz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind == OP_WRITE)
            shadow_volume[int'(addr)] = value;
        else
            pending_answers.push_back(blend_at(cx, cy, cz));
        sent_items++;
    endtask

    task automatic write_voxel(input int unsigned addr, input logic [SAMPLE_W-1:0] value);
        send_item(OP_WRITE, addr[VADDR_W-1:0], value, COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic query_point(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [COORD_W-1:0] cz);
        send_item(OP_QUERY, VADDR_W'($urandom), SAMPLE_W'($urandom), cx, cy, cz);
    endtask

    // Waits for the block to drain, then rewrites all three sizes.  The volume
    // is forgotten, since addresses now map to different voxels.
    task automatic set_sizes(input int unsigned sx, input int unsigned sy, input int unsigned sz);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_SIZE_X; i_cfg_data <= sx[SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SIZE_Y; i_cfg_data <= sy[SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SIZE_Z; i_cfg_data <= sz[SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ext_x = sx; ext_y = sy; ext_z = sz;
        shadow_volume.delete();
    endtask

    // Writes every voxel of the current volume with random samples, occasionally
    // an extreme value.
    task automatic fill_volume();
        int unsigned words;
        logic [SAMPLE_W-1:0] v;
        words = ext_x * ext_y * ext_z;
        for (int unsigned a = 0; a < words; a++) begin
            case ($urandom_range(0, 7))
                0: v = 16'hFFFF;
                1: v = 16'h0000;
                default: v = SAMPLE_W'($urandom);
            endcase
            write_voxel(a, v);
        end
    endtask

    // A coordinate in Q8.8 from the given integer part, which is the base plus one, and a fraction.
    function automatic logic [COORD_W-1:0] q88(input int whole, input int unsigned frac);
        logic [COORD_W-1:0] r;
        r = {whole[7:0], frac[7:0]};
        return r;
    endfunction

    // A random coordinate on one axis: mostly inside, sometimes on the edge or
    // just outside, sometimes fully random.
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned ext);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75 && ext >= 3)
            return q88($urandom_range(2, ext - 1), $urandom_range(0, 255));
        if (pick < 88)
            return q88($urandom_range(0, 1) ? 1 : ext, $urandom_range(0, 255));
        return COORD_W'($urandom);
    endfunction

    // Directed: a small volume, extremes of coordinates and fractions, the base-0
    // exclusion, the upper edge, negative coordinates, writes to the last memory word.
    task automatic test_directed_edges();
        set_sizes(4, 4, 4);
        fill_volume();
        query_point(q88(2, 0), q88(2, 0), q88(2, 0));
        query_point(q88(2, 255), q88(2, 255), q88(2, 255));
        query_point(q88(3, 255), q88(3, 255), q88(3, 255));
        query_point(q88(3, 128), q88(2, 32), q88(3, 1));
        query_point(q88(1, 255), q88(2, 0), q88(2, 0));
        query_point(q88(2, 0), q88(1, 0), q88(2, 0));
        query_point(q88(2, 0), q88(2, 0), q88(4, 0));
        query_point(16'h8000, 16'h7FFF, q88(2, 0));
        query_point(16'hFFFF, q88(2, 0), 16'h0000);
        query_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        query_point(16'h8000, 16'h8000, 16'h8000);
        write_voxel(VOL_WORDS - 1, 16'hFFFF);
        write_voxel(VOL_WORDS - 1, 16'h0000);
    endtask

    // Directed: the largest volume corners, touching only written voxels.
    task automatic test_largest_sizes();
        int unsigned a;
        set_sizes(64, 64, 64);
        for (int k = 61; k < 63; k++)
            for (int j = 61; j < 63; j++)
                for (int i = 61; i < 64; i++) begin
                    a = i + (j + k * 64) * 64;
                    write_voxel(a, 16'hFFFF);
                end
        query_point(q88(62, 255), q88(62, 255), q88(62, 255));
        query_point(q88(63, 0), q88(62, 0), q88(62, 0));
        query_point(q88(64, 0), q88(62, 0), q88(62, 0));
    endtask

    // Sizes 0 and 1 leave no inside cell; size 2 and 3 border cases too.
    task automatic test_degenerate_sizes();
        set_sizes(2, 3, 127);
        for (int n = 0; n < 6; n++)
            query_point(pick_coord(3), pick_coord(3), pick_coord(3));
        set_sizes(0, 1, 3);
        for (int n = 0; n < 6; n++)
            query_point(pick_coord(3), pick_coord(3), pick_coord(3));
    endtask

    // Random phases: a small volume is filled, then a stream of queries mixed with
    // rewrites of voxels already known.
    task automatic test_random_volumes();
        int unsigned sx, sy, sz, words;
        while (sent_items < 1650) begin
            sx = $urandom_range(3, 6);
            sy = $urandom_range(3, 6);
            sz = $urandom_range(3, 5);
            set_sizes(sx, sy, sz);
            fill_volume();
            words = sx * sy * sz;
            for (int n = 0; n < 120; n++) begin
                if ($urandom_range(0, 4) == 0)
                    write_voxel($urandom_range(0, words - 1), SAMPLE_W'($urandom));
                else
                    query_point(pick_coord(sx), pick_coord(sy), pick_coord(sz));
            end
        end
    endtask

    // Result side: random stalls, each item compared with the oldest expectation.
    initial begin
        t_answer want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_ready && o_valid) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result item with nothing expected: value %0h in_range %0b",
                             $time, o_interp_value, o_in_range);
                    error_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_interp_value !== want.blend) begin
                        $display("%0t: interp_value expected %0h actual %0h",
                                 $time, want.blend, o_interp_value);
                        error_count++;
                    end
                    if (o_in_range !== want.in_cell) begin
                        $display("%0t: in_range expected %0b actual %0b",
                                 $time, want.in_cell, o_in_range);
                        error_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : (gap_length() == 0);
        end
    end

    // Watchdog: counts cycles in which no item moves on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        error_count     = 0;
        sent_items      = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = OP_WRITE;
        i_voxel_address = '0;
        i_voxel_value   = '0;
        i_coord_x       = '0;
        i_coord_y       = '0;
        i_coord_z       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_SIZE_X;
        i_cfg_data      = '0;
        ext_x = 64; ext_y = 64; ext_z = 64;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_largest_sizes();
        test_degenerate_sizes();
        test_random_volumes();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        pass_ok = (error_count == 0);
        if (pass_ok)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
